@@ hdl/lzssd_pkg.sv @@
// shared types and constants of the lzss bitstream decompressor
`timescale 1ns / 1ps

package lzssd_pkg;

    localparam int OFFSET_BITS_DEF      = 13;
    localparam int LENGTH_CODE_BITS_DEF = 4;
    localparam int MIN_COPY_DEF         = 3;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_SIZE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_CHECKSUM = 2'd1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_SIZE     = 2'd2;
    localparam logic [1:0] ST_CHECKSUM = 2'd3;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       done_res;
        logic [1:0] status;
        logic       run_end;
    } result_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] expected_size;
        logic [CFG_DATA_W-1:0] expected_checksum;
    } cfg_t;

endpackage

@@ hdl/lzssd_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps

module lzssd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/lzssd_out_stage.sv @@
// output register between the decoder and the result channel
`timescale 1ns / 1ps

module lzssd_out_stage
    import lzssd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  result_t    res,
    output logic       free,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       is_data,
    output logic       done_res,
    output logic [1:0] status,
    output logic       run_end
);

    logic    valid_reg;
    result_t data_reg;

    assign free = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = data_reg.out_byte;
    assign is_data   = data_reg.is_data;
    assign done_res  = data_reg.done_res;
    assign status    = data_reg.status;
    assign run_end   = data_reg.run_end;

endmodule

@@ hdl/lzssd_core.sv @@
// token decoder, copy engine and dictionary control
`timescale 1ns / 1ps

module lzssd_core
    import lzssd_pkg::*;
#(
    parameter int OFFSET_BITS      = OFFSET_BITS_DEF,
    parameter int LENGTH_CODE_BITS = LENGTH_CODE_BITS_DEF,
    parameter int MIN_COPY         = MIN_COPY_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             in_byte,
    input  logic                   start_req,
    input  logic                   final_byte,
    input  cfg_t                   cfg,
    output logic                   res_push,
    output result_t                res,
    input  logic                   res_free,
    output logic                   mem_we,
    output logic [OFFSET_BITS-1:0] mem_waddr,
    output logic [7:0]             mem_wdata,
    output logic                   mem_re,
    output logic [OFFSET_BITS-1:0] mem_raddr,
    input  logic [7:0]             mem_rdata
);

    localparam int AW    = OFFSET_BITS;
    localparam int ACC_W = (OFFSET_BITS > 8) ? OFFSET_BITS : 8;
    localparam int GW    = $clog2(ACC_W + 1);
    localparam int LW    = LENGTH_CODE_BITS + 1;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_BITS    = 3'd1;
    localparam logic [2:0] S_COPY_RD = 3'd2;
    localparam logic [2:0] S_COPY_WR = 3'd3;
    localparam logic [2:0] S_END     = 3'd4;

    localparam logic [1:0] PH_FLAG = 2'd0;
    localparam logic [1:0] PH_LIT  = 2'd1;
    localparam logic [1:0] PH_OFF  = 2'd2;
    localparam logic [1:0] PH_LEN  = 2'd3;

    logic [2:0]       state_reg, state_next;
    logic [7:0]       byte_reg, byte_next;
    logic             final_reg, final_next;
    logic [2:0]       bit_idx_reg, bit_idx_next;
    logic [1:0]       phase_reg, phase_next;
    logic [GW-1:0]    gath_reg, gath_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [AW-1:0]    off_reg, off_next;
    logic [AW-1:0]    head_reg, head_next;
    logic [31:0]      prod_reg, prod_next;
    logic [31:0]      sum_reg, sum_next;
    logic             fin_reg, fin_next;
    logic [AW-1:0]    copy_addr_reg, copy_addr_next;
    logic [LW-1:0]    copy_rem_reg, copy_rem_next;
    logic             bits_left_reg, bits_left_next;
    logic             fwd_reg, fwd_next;
    logic [7:0]       fwd_data_reg, fwd_data_next;
    logic             rvalid_reg, rvalid_next;

    logic             bit_cur;
    logic [ACC_W-1:0] acc_shift;
    logic [GW-1:0]    gath_inc;
    logic [AW-1:0]    offset_cur;
    logic [LW-1:0]    copy_len;
    logic             room_short;
    logic             lit_over;
    logic [7:0]       copy_data;
    logic [2:0]       after_byte;

    // an entry counts as written once the running output count has reached it
    function automatic logic is_written(input logic [AW-1:0] a, input logic [31:0] p);
        is_written = (p[31:AW] != '0) || ((a != '0) && (32'(a) <= p));
    endfunction

    function automatic logic [1:0] end_status(input logic invalid,
                                              input logic [31:0] prod,
                                              input logic [31:0] sum,
                                              input cfg_t c);
        if (invalid)
            end_status = ST_INVALID;
        else if (prod != c.expected_size)
            end_status = ST_SIZE;
        else if (sum != c.expected_checksum)
            end_status = ST_CHECKSUM;
        else
            end_status = ST_OK;
    endfunction

    assign bit_cur    = byte_reg[bit_idx_reg];
    assign acc_shift  = {acc_reg[ACC_W-2:0], bit_cur};
    assign gath_inc   = gath_reg + 1'b1;
    assign offset_cur = acc_shift[AW-1:0];
    assign copy_len   = LW'(acc_shift[LENGTH_CODE_BITS-1:0]) + LW'(MIN_COPY);
    assign room_short = ({1'b0, prod_reg} + 33'(copy_len)) > {1'b0, cfg.expected_size};
    assign lit_over   = prod_reg >= cfg.expected_size;
    assign copy_data  = fwd_reg ? fwd_data_reg : (rvalid_reg ? mem_rdata : 8'd0);
    assign after_byte = final_reg ? S_END : S_IDLE;
    assign in_ready   = (state_reg == S_IDLE);

    always_comb
    begin
        logic [31:0] sum_base;
        logic        fin_base;

        state_next     = state_reg;
        byte_next      = byte_reg;
        final_next     = final_reg;
        bit_idx_next   = bit_idx_reg;
        phase_next     = phase_reg;
        gath_next      = gath_reg;
        acc_next       = acc_reg;
        off_next       = off_reg;
        head_next      = head_reg;
        prod_next      = prod_reg;
        sum_next       = sum_reg;
        fin_next       = fin_reg;
        copy_addr_next = copy_addr_reg;
        copy_rem_next  = copy_rem_reg;
        bits_left_next = bits_left_reg;
        fwd_next       = fwd_reg;
        fwd_data_next  = fwd_data_reg;
        rvalid_next    = rvalid_reg;

        res_push  = 1'b0;
        res       = '0;
        mem_we    = 1'b0;
        mem_waddr = head_reg;
        mem_wdata = copy_data;
        mem_re    = 1'b0;
        mem_raddr = copy_addr_reg;
        sum_base  = sum_reg;
        fin_base  = fin_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (start_req)
                    begin
                        head_next  = AW'(1);
                        prod_next  = '0;
                        sum_next   = '0;
                        phase_next = PH_FLAG;
                        gath_next  = '0;
                        acc_next   = '0;
                        off_next   = '0;
                        fin_next   = 1'b0;
                        sum_base   = '0;
                        fin_base   = 1'b0;
                    end
                    // a finished entry drops bytes until the next start
                    if (!fin_base)
                    begin
                        sum_next     = sum_base + 32'(in_byte);
                        byte_next    = in_byte;
                        final_next   = final_byte;
                        bit_idx_next = 3'd7;
                        state_next   = S_BITS;
                    end
                end
            end

            S_BITS:
            begin
                if (phase_reg == PH_FLAG)
                begin
                    phase_next = bit_cur ? PH_LIT : PH_OFF;
                    gath_next  = '0;
                    acc_next   = '0;
                    if (bit_idx_reg == 3'd0)
                        state_next = after_byte;
                    else
                        bit_idx_next = bit_idx_reg - 3'd1;
                end
                else if (phase_reg == PH_LIT && gath_inc == GW'(8))
                begin
                    if (res_free)
                    begin
                        res_push = 1'b1;
                        if (lit_over)
                        begin
                            res.done_res = 1'b1;
                            res.status   = ST_INVALID;
                            res.run_end  = 1'b1;
                            fin_next     = 1'b1;
                            state_next   = S_IDLE;
                        end
                        else
                        begin
                            res.out_byte = acc_shift[7:0];
                            res.is_data  = 1'b1;
                            res.run_end  = !final_reg;
                            mem_we       = 1'b1;
                            mem_wdata    = acc_shift[7:0];
                            head_next    = head_reg + 1'b1;
                            prod_next    = prod_reg + 32'd1;
                            phase_next   = PH_FLAG;
                            gath_next    = gath_inc;
                            acc_next     = acc_shift;
                            if (bit_idx_reg == 3'd0)
                                state_next = after_byte;
                            else
                                bit_idx_next = bit_idx_reg - 3'd1;
                        end
                    end
                end
                else if (phase_reg == PH_OFF && gath_inc == GW'(OFFSET_BITS))
                begin
                    if (offset_cur == '0)
                    begin
                        // end token: rest of the byte is ignored
                        if (res_free)
                        begin
                            res_push     = 1'b1;
                            res.done_res = 1'b1;
                            res.status   = end_status(1'b0, prod_reg, sum_reg, cfg);
                            res.run_end  = 1'b1;
                            fin_next     = 1'b1;
                            state_next   = S_IDLE;
                        end
                    end
                    else
                    begin
                        off_next   = offset_cur;
                        phase_next = PH_LEN;
                        gath_next  = '0;
                        acc_next   = '0;
                        if (bit_idx_reg == 3'd0)
                            state_next = after_byte;
                        else
                            bit_idx_next = bit_idx_reg - 3'd1;
                    end
                end
                else if (phase_reg == PH_LEN && gath_inc == GW'(LENGTH_CODE_BITS))
                begin
                    if (room_short)
                    begin
                        if (res_free)
                        begin
                            res_push     = 1'b1;
                            res.done_res = 1'b1;
                            res.status   = ST_INVALID;
                            res.run_end  = 1'b1;
                            fin_next     = 1'b1;
                            state_next   = S_IDLE;
                        end
                    end
                    else
                    begin
                        copy_addr_next = off_reg;
                        copy_rem_next  = copy_len;
                        phase_next     = PH_FLAG;
                        gath_next      = '0;
                        acc_next       = '0;
                        bits_left_next = (bit_idx_reg != 3'd0);
                        if (bit_idx_reg != 3'd0)
                            bit_idx_next = bit_idx_reg - 3'd1;
                        state_next = S_COPY_RD;
                    end
                end
                else
                begin
                    gath_next = gath_inc;
                    acc_next  = acc_shift;
                    if (bit_idx_reg == 3'd0)
                        state_next = after_byte;
                    else
                        bit_idx_next = bit_idx_reg - 3'd1;
                end
            end

            S_COPY_RD:
            begin
                mem_re         = 1'b1;
                fwd_next       = 1'b0;
                rvalid_next    = is_written(copy_addr_reg, prod_reg);
                copy_addr_next = copy_addr_reg + 1'b1;
                state_next     = S_COPY_WR;
            end

            S_COPY_WR:
            begin
                if (res_free)
                begin
                    res_push      = 1'b1;
                    res.out_byte  = copy_data;
                    res.is_data   = 1'b1;
                    res.run_end   = (copy_rem_reg == LW'(1)) && !final_reg;
                    mem_we        = 1'b1;
                    head_next     = head_reg + 1'b1;
                    prod_next     = prod_reg + 32'd1;
                    copy_rem_next = copy_rem_reg - LW'(1);
                    if (copy_rem_reg == LW'(1))
                    begin
                        state_next = bits_left_reg ? S_BITS : after_byte;
                    end
                    else
                    begin
                        // next read may hit the entry written in this cycle
                        mem_re         = 1'b1;
                        fwd_next       = (copy_addr_reg == head_reg);
                        fwd_data_next  = copy_data;
                        rvalid_next    = is_written(copy_addr_reg, prod_reg + 32'd1);
                        copy_addr_next = copy_addr_reg + 1'b1;
                    end
                end
            end

            S_END:
            begin
                // bits ran out before an end token
                if (res_free)
                begin
                    res_push     = 1'b1;
                    res.done_res = 1'b1;
                    res.status   = ST_INVALID;
                    res.run_end  = 1'b1;
                    fin_next     = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_FLAG;
            gath_reg      <= '0;
            acc_reg       <= '0;
            off_reg       <= '0;
            head_reg      <= AW'(1);
            prod_reg      <= '0;
            sum_reg       <= '0;
            fin_reg       <= 1'b0;
            bit_idx_reg   <= '0;
            final_reg     <= 1'b0;
            copy_rem_reg  <= '0;
            bits_left_reg <= 1'b0;
            fwd_reg       <= 1'b0;
            rvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            gath_reg      <= gath_next;
            acc_reg       <= acc_next;
            off_reg       <= off_next;
            head_reg      <= head_next;
            prod_reg      <= prod_next;
            sum_reg       <= sum_next;
            fin_reg       <= fin_next;
            bit_idx_reg   <= bit_idx_next;
            final_reg     <= final_next;
            copy_rem_reg  <= copy_rem_next;
            bits_left_reg <= bits_left_next;
            fwd_reg       <= fwd_next;
            rvalid_reg    <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg      <= byte_next;
        copy_addr_reg <= copy_addr_next;
        fwd_data_reg  <= fwd_data_next;
    end

`ifndef SYNTH
    a_head_tracks_count: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg == AW'(prod_reg + 32'd1))
        else $error("write head out of step with output count");

    a_finished_idle: assert property (@(posedge clk) disable iff (!rst_n)
        fin_reg |-> state_reg == S_IDLE)
        else $error("decoder busy after the entry finished");

    a_copy_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COPY_RD || state_reg == S_COPY_WR) |-> copy_rem_reg != '0)
        else $error("copy running with nothing left");

    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> res_free)
        else $error("result pushed into a full output register");

    a_write_is_data: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (res_push && res.is_data && !res.done_res))
        else $error("dictionary written without a data result");
`endif

endmodule

@@ hdl/lzss_bitstream_decompressor.sv @@
// top level of the lzss bitstream decompressor
`timescale 1ns / 1ps

// LZSS decompressor: compressed bytes are decoded most significant bit first, one bit
// per clock while bits are pending, no copy runs and the output register has room. A
// byte is taken in while the decoder is idle, then its bits are decoded; when the bits
// of the last byte of an entry run out before an end token, a status result follows.
// A copy token issues the first dictionary read, then writes each copied byte while
// issuing the next read, through the single read port of the dictionary ram, and waits
// while the result channel holds out_ready low. A byte that completes an end token stops
// at that bit, and a byte taken after the entry is done is dropped. The dictionary needs
// no clearing pass: entries not yet written in the current entry read as zero. A new
// item is taken only while the decoder waits for input; results sit in an output
// register. The user must write expected_size and expected_checksum between items only; the block does not check this.

module lzss_bitstream_decompressor
    import lzssd_pkg::*;
#(
    parameter int OFFSET_BITS      = OFFSET_BITS_DEF,
    parameter int LENGTH_CODE_BITS = LENGTH_CODE_BITS_DEF,
    parameter int MIN_COPY         = MIN_COPY_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            in_byte,
    input  logic                  start_req,
    input  logic                  final_byte,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_byte,
    output logic                  is_data,
    output logic                  done_res,
    output logic [1:0]            status,
    output logic                  run_end,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DICT_SIZE = 1 << OFFSET_BITS;

    cfg_t                   cfg_reg;
    logic                   res_push;
    result_t                res;
    logic                   res_free;
    logic                   mem_we;
    logic [OFFSET_BITS-1:0] mem_waddr;
    logic [7:0]             mem_wdata;
    logic                   mem_re;
    logic [OFFSET_BITS-1:0] mem_raddr;
    logic [7:0]             mem_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_EXPECTED_SIZE:     cfg_reg.expected_size     <= cfg_data;
                REG_EXPECTED_CHECKSUM: cfg_reg.expected_checksum <= cfg_data;
                default:               cfg_reg <= cfg_reg;
            endcase
        end
    end

    lzssd_core #(
        .OFFSET_BITS      (OFFSET_BITS),
        .LENGTH_CODE_BITS (LENGTH_CODE_BITS),
        .MIN_COPY         (MIN_COPY)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .start_req  (start_req),
        .final_byte (final_byte),
        .cfg        (cfg_reg),
        .res_push   (res_push),
        .res        (res),
        .res_free   (res_free),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    lzssd_ram #(
        .WIDTH (8),
        .DEPTH (DICT_SIZE)
    ) u_dict (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    lzssd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .res       (res),
        .free      (res_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .is_data   (is_data),
        .done_res  (done_res),
        .status    (status),
        .run_end   (run_end)
    );

endmodule

@@ sim/lzss_decode_checker.sv @@
// checker for the lzss decompressor: predicts every result and compares on each output transfer
`timescale 1ns / 1ps

module lzss_decode_checker
    import lzssd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [7:0]            in_byte,
    input  logic                  start_req,
    input  logic                  final_byte,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [7:0]            out_byte,
    input  logic                  is_data,
    input  logic                  done_res,
    input  logic [1:0]            status,
    input  logic                  run_end,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic [31:0]           mismatches,
    output logic [31:0]           outstanding
);

    localparam int DICT_DEPTH = 1 << OFFSET_BITS_DEF;

    typedef enum logic [1:0] {
        TOK_FLAG,
        TOK_LITERAL,
        TOK_OFFSET,
        TOK_LENGTH
    } tok_phase_t;

    logic [7:0]                 dict_mem [0:DICT_DEPTH-1];
    logic [OFFSET_BITS_DEF-1:0] dict_head;
    logic [OFFSET_BITS_DEF-1:0] copy_src;
    logic [31:0]                out_count;
    logic [31:0]                in_sum;
    logic [15:0]                bit_acc;
    int                         bit_count;
    tok_phase_t                 tok_phase;
    logic                       entry_done;
    logic [31:0]                lim_size;
    logic [31:0]                lim_sum;

    result_t expected_results[$];
    result_t byte_results[$];

    task automatic clear_entry();
        int k;
        for (k = 0; k < DICT_DEPTH; k++)
            dict_mem[k] = 8'h00;
        dict_head  = OFFSET_BITS_DEF'(1);
        copy_src   = '0;
        out_count  = '0;
        in_sum     = '0;
        bit_acc    = '0;
        bit_count  = 0;
        tok_phase  = TOK_FLAG;
        entry_done = 1'b0;
    endtask

    task automatic push_data(input logic [7:0] v);
        result_t r;
        dict_mem[dict_head] = v;
        dict_head = dict_head + 1'b1;
        out_count = out_count + 1;
        r = '0;
        r.out_byte = v;
        r.is_data  = 1'b1;
        byte_results.push_back(r);
    endtask

    // status priority: invalid stream, then size, then checksum
    task automatic close_entry(input logic invalid);
        result_t r;
        r = '0;
        r.done_res = 1'b1;
        if (invalid)
            r.status = ST_INVALID;
        else if (out_count != lim_size)
            r.status = ST_SIZE;
        else if (in_sum != lim_sum)
            r.status = ST_CHECKSUM;
        else
            r.status = ST_OK;
        byte_results.push_back(r);
        entry_done = 1'b1;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic s, input logic f);
        logic [31:0]                len;
        logic [31:0]                room;
        logic [OFFSET_BITS_DEF-1:0] rd;
        logic                       bv;
        result_t                    r;
        int                         k;
        int                         i;
        byte_results.delete();
        if (s)
            clear_entry();
        if (!entry_done)
        begin
            in_sum = in_sum + 32'(b);
            for (k = 7; k >= 0; k--)
            begin
                if (!entry_done)
                begin
                    bv = b[k];
                    if (tok_phase == TOK_FLAG)
                    begin
                        tok_phase = bv ? TOK_LITERAL : TOK_OFFSET;
                        bit_count = 0;
                        bit_acc   = '0;
                    end
                    else
                    begin
                        bit_acc   = {bit_acc[14:0], bv};
                        bit_count = bit_count + 1;
                        case (tok_phase)
                            TOK_LITERAL:
                            begin
                                if (bit_count == 8)
                                begin
                                    if (out_count >= lim_size)
                                        close_entry(1'b1);
                                    else
                                    begin
                                        push_data(bit_acc[7:0]);
                                        tok_phase = TOK_FLAG;
                                    end
                                end
                            end
                            TOK_OFFSET:
                            begin
                                if (bit_count == OFFSET_BITS_DEF)
                                begin
                                    // zero offset is the end token
                                    if (bit_acc == 0)
                                        close_entry(1'b0);
                                    else
                                    begin
                                        copy_src  = bit_acc[OFFSET_BITS_DEF-1:0];
                                        tok_phase = TOK_LENGTH;
                                        bit_count = 0;
                                        bit_acc   = '0;
                                    end
                                end
                            end
                            default:
                            begin
                                if (bit_count == LENGTH_CODE_BITS_DEF)
                                begin
                                    len  = bit_acc + MIN_COPY_DEF;
                                    room = (lim_size >= out_count) ? lim_size - out_count : 0;
                                    if (len > room)
                                        close_entry(1'b1);
                                    else
                                    begin
                                        // reads may see bytes written earlier in this copy
                                        for (i = 0; i < len; i++)
                                        begin
                                            rd = copy_src + i[OFFSET_BITS_DEF-1:0];
                                            push_data(dict_mem[rd]);
                                        end
                                        tok_phase = TOK_FLAG;
                                    end
                                end
                            end
                        endcase
                    end
                end
            end
            if (!entry_done && f)
                close_entry(1'b1);
            if (byte_results.size() > 0)
            begin
                r = byte_results.pop_back();
                r.run_end = 1'b1;
                byte_results.push_back(r);
            end
            foreach (byte_results[j])
                expected_results.push_back(byte_results[j]);
        end
    endtask

    initial
    begin
        lim_size    = '0;
        lim_sum     = '0;
        mismatches  = '0;
        outstanding = '0;
        clear_entry();
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_EXPECTED_SIZE)
                    lim_size = cfg_data;
                else if (cfg_index == REG_EXPECTED_CHECKSUM)
                    lim_sum = cfg_data;
            end
            if (in_valid && in_ready)
                decode_byte(in_byte, start_req, final_byte);
            if (out_valid && out_ready)
            begin
                got.out_byte = out_byte;
                got.is_data  = is_data;
                got.done_res = done_res;
                got.status   = status;
                got.run_end  = run_end;
                if (expected_results.size() == 0)
                begin
                    $display({"%0t unexpected transfer: expected none, ",
                              "actual byte=%02h data=%0b done=%0b status=%0d end=%0b"},
                             $time, got.out_byte, got.is_data, got.done_res, got.status,
                             got.run_end);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        $display({"%0t mismatch: expected byte=%02h data=%0b done=%0b ",
                                  "status=%0d end=%0b, actual byte=%02h data=%0b ",
                                  "done=%0b status=%0d end=%0b"},
                                 $time, want.out_byte, want.is_data, want.done_res,
                                 want.status, want.run_end, got.out_byte, got.is_data,
                                 got.done_res, got.status, got.run_end);
                        mismatches = mismatches + 1;
                    end
                end
            end
            outstanding = expected_results.size();
        end
    end

endmodule

@@ sim/tb_lzss_bitstream_decompressor.sv @@
// testbench top for the lzss decompressor: builds token streams, drives the block
`timescale 1ns / 1ps

module tb_lzss_bitstream_decompressor;
    import lzssd_pkg::*;

    localparam int          RANDOM_ITEMS  = 120;
    localparam int          SETTLE_CYCLES = 64;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int          OFFSET_MAX    = (1 << OFFSET_BITS_DEF) - 1;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    logic [7:0]            in_byte    = 8'h00;
    logic                  start_req  = 1'b0;
    logic                  final_byte = 1'b0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    logic [7:0]            out_byte;
    logic                  is_data;
    logic                  done_res;
    logic [1:0]            status;
    logic                  run_end;
    logic                  cfg_valid  = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic [31:0]           mismatches;
    logic [31:0]           outstanding;

    int          snd_idle    = 6;
    int          rcv_idle    = 76;
    int          bytes_sent  = 0;
    int unsigned cycle_count = 0;

    bit          stream_bits[$];
    logic [7:0]  stream_bytes[$];
    int unsigned plan_size;
    logic [31:0] plan_sum;

    lzss_bitstream_decompressor u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .start_req  (start_req),
        .final_byte (final_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .is_data    (is_data),
        .done_res   (done_res),
        .status     (status),
        .run_end    (run_end),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    lzss_decode_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .start_req   (start_req),
        .final_byte  (final_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .is_data     (is_data),
        .done_res    (done_res),
        .status      (status),
        .run_end     (run_end),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= rcv_idle);

    task automatic send_byte(input logic [7:0] b, input logic s, input logic f);
        // idling profile follows progress through the run
        if (bytes_sent < 70)
        begin
            snd_idle = 6;
            rcv_idle = 76;
        end
        else if (bytes_sent < 140)
        begin
            snd_idle = 76;
            rcv_idle = 6;
        end
        else
        begin
            snd_idle = 0;
            rcv_idle = 0;
        end
        bytes_sent = bytes_sent + 1;
        while ($urandom_range(0, 99) < snd_idle)
            @(negedge clk);
        in_valid   = 1'b1;
        in_byte    = b;
        start_req  = s;
        final_byte = f;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // block must be idle: every result in and trailing bits worked off
    task automatic set_limits(input logic [31:0] sz, input logic [31:0] sum);
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
        write_reg(REG_EXPECTED_SIZE, sz);
        write_reg(REG_EXPECTED_CHECKSUM, sum);
    endtask

    task automatic put_bits(input logic [15:0] v, input int w);
        int k;
        for (k = w - 1; k >= 0; k--)
            stream_bits.push_back(v[k]);
    endtask

    task automatic new_stream();
        stream_bits.delete();
        stream_bytes.delete();
        plan_size = 0;
        plan_sum  = '0;
    endtask

    task automatic tok_literal(input logic [7:0] v);
        put_bits(16'd1, 1);
        put_bits({8'h00, v}, 8);
        plan_size = plan_size + 1;
    endtask

    task automatic tok_copy(input logic [15:0] off, input logic [3:0] code);
        put_bits(16'd0, 1);
        put_bits(off, OFFSET_BITS_DEF);
        put_bits({12'h000, code}, LENGTH_CODE_BITS_DEF);
        plan_size = plan_size + 32'(code) + MIN_COPY_DEF;
    endtask

    task automatic tok_end();
        put_bits(16'd0, 1 + OFFSET_BITS_DEF);
    endtask

    // pad with random bits after the last token, then cut into bytes msb first
    task automatic pack();
        logic [7:0] v;
        int         k;
        int         j;
        while (stream_bits.size() % 8 != 0)
            stream_bits.push_back(1'($urandom_range(0, 1)));
        for (k = 0; k < stream_bits.size(); k += 8)
        begin
            for (j = 0; j < 8; j++)
                v[7 - j] = stream_bits[k + j];
            stream_bytes.push_back(v);
            plan_sum = plan_sum + 32'(v);
        end
    endtask

    task automatic send_stream(input logic with_start, input logic with_final, input int keep);
        int k;
        for (k = 0; k < keep; k++)
            send_byte(stream_bytes[k], with_start && k == 0, with_final && k == keep - 1);
    endtask

    initial
    begin
        int          kind;
        int          ntok;
        int          keep;
        int          k;
        int          counted;
        int unsigned hi;
        logic        abandon;
        logic [31:0] sz;
        logic [31:0] sum;

        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // first entry straight after reset, with no start request
        new_stream();
        tok_literal(8'h00);
        tok_literal(8'hff);
        tok_end();
        pack();
        set_limits(plan_size, plan_sum);
        send_stream(1'b0, 1'b1, stream_bytes.size());

        // empty entry: two zero bytes
        new_stream();
        tok_end();
        put_bits(16'd0, 2);
        pack();
        set_limits(32'd0, 32'd0);
        send_stream(1'b1, 1'b1, stream_bytes.size());

        // copy overlapping its own output, longest length
        new_stream();
        tok_literal(8'h41);
        tok_copy(16'd1, 4'hf);
        tok_end();
        pack();
        set_limits(plan_size, plan_sum);
        send_stream(1'b1, 1'b1, stream_bytes.size());

        // copy from the top of the dictionary, wrapping to index zero
        new_stream();
        tok_copy(16'(OFFSET_MAX), 4'h0);
        tok_literal(8'h5a);
        tok_end();
        pack();
        set_limits(plan_size, plan_sum);
        send_stream(1'b1, 1'b1, stream_bytes.size());
        // bytes after done are ignored
        send_byte(8'hff, 1'b0, 1'b0);
        send_byte(8'h80, 1'b0, 1'b1);

        // literal with no room left
        new_stream();
        tok_literal(8'hc3);
        tok_end();
        pack();
        set_limits(32'd0, plan_sum);
        send_stream(1'b1, 1'b1, stream_bytes.size());

        // copy longer than the remaining room
        new_stream();
        tok_copy(16'd1, 4'h0);
        tok_end();
        pack();
        set_limits(32'd2, plan_sum);
        send_stream(1'b1, 1'b1, stream_bytes.size());

        // bits run out before the end token
        new_stream();
        tok_literal(8'h33);
        tok_end();
        pack();
        set_limits(plan_size, plan_sum);
        send_stream(1'b1, 1'b1, stream_bytes.size() - 1);

        // size mismatch
        new_stream();
        tok_literal(8'h7e);
        tok_end();
        pack();
        set_limits(32'hffff_ffff, plan_sum);
        send_stream(1'b1, 1'b1, stream_bytes.size());

        // checksum mismatch
        new_stream();
        tok_literal(8'h01);
        tok_end();
        pack();
        set_limits(plan_size, 32'hffff_ffff);
        send_stream(1'b1, 1'b1, stream_bytes.size());

        // entry left open, the next start request abandons it
        new_stream();
        tok_literal(8'h11);
        tok_copy(16'd1, 4'h2);
        pack();
        set_limits(plan_size + 4, plan_sum);
        send_stream(1'b1, 1'b0, stream_bytes.size());

        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            new_stream();
            if (kind < 8)
            begin
                // noise entry
                keep = $urandom_range(1, 4);
                for (k = 0; k < keep; k++)
                    stream_bytes.push_back(8'($urandom_range(0, 255)));
                set_limits($urandom, $urandom);
                send_stream(1'b1, 1'b1, keep);
                counted = counted + keep;
            end
            else
            begin
                ntok = $urandom_range(1, 6);
                for (k = 0; k < ntok; k++)
                begin
                    if ($urandom_range(0, 99) < 45)
                        tok_literal(8'($urandom_range(0, 255)));
                    else
                    begin
                        hi = (plan_size + 1 < OFFSET_MAX) ? plan_size + 1 : OFFSET_MAX;
                        case ($urandom_range(0, 9))
                            7, 8:    tok_copy(16'($urandom_range(1, OFFSET_MAX)),
                                              4'($urandom_range(0, 15)));
                            9:       tok_copy(16'(OFFSET_MAX), 4'($urandom_range(0, 15)));
                            default: tok_copy(16'($urandom_range(1, hi)),
                                              4'($urandom_range(0, 15)));
                        endcase
                    end
                end
                abandon = (kind >= 94);
                if (!abandon)
                    tok_end();
                pack();
                keep = stream_bytes.size();
                sz   = plan_size;
                sum  = plan_sum;
                if (kind < 50)
                    ;
                else if (kind < 60)
                    sum = $urandom;
                else if (kind < 68)
                    sz = plan_size + $urandom_range(1, 5);
                else if (kind < 76)
                    sz = $urandom_range(0, plan_size - 1);
                else if (kind < 84)
                    keep = $urandom_range(1, stream_bytes.size() - 1);
                // 84 to 89 keep the previous limits and follow straight on
                if (kind < 84 || kind >= 90)
                    set_limits(sz, sum);
                send_stream(1'b1, !abandon, keep);
                counted = counted + keep;
                if (!abandon && $urandom_range(0, 99) < 15)
                begin
                    ntok = $urandom_range(1, 3);
                    for (k = 0; k < ntok; k++)
                        send_byte(8'($urandom_range(0, 255)), 1'b0,
                                  1'($urandom_range(0, 1)));
                end
            end
        end

        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
